// ===== hdl/fcrd_pkg.sv =====
package fcrd_pkg;

    localparam int PIXEL_W   = 24;
    localparam int ROW_NUM_W = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_CLR
    } t_state;

    typedef struct packed {
        logic cfg_wr;
        logic load;
        logic clr_start;
        logic pix_step;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic col_last;
        logic pix_emit;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/fcrd_ctrl.sv =====
module fcrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_row_absent,
    output logic              o_in_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  fcrd_pkg::t_status i_status,
    output fcrd_pkg::t_cmd    o_cmd
);
    import fcrd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready  = 1'b1;
                o_in_ready   = !i_cfg_valid;
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    if (i_row_absent) begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLR;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (!i_status.pix_emit || i_status.out_free) begin
                    o_cmd.pix_step = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLR: begin
                if (!i_status.col_last || i_status.out_free) begin
                    o_cmd.clr_step = 1'b1;
                    if (i_status.col_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fcrd_dpath.sv =====
module fcrd_dpath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcrd_pkg::t_cmd                      i_cmd,
    output fcrd_pkg::t_status                   o_status,
    input  logic [fcrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fcrd_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [fcrd_pkg::PIXEL_W-1:0]        i_pixel_value,
    input  logic                                i_force_full,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fcrd_pkg::ROW_NUM_W-1:0]      o_row_number,
    output logic                                o_row_changed,
    output logic                                o_frame_last
);
    import fcrd_pkg::*;

    localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW       = CW + RW;
    localparam int DEPTH    = 1 << AW;
    localparam int RST_W    = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int RST_H    = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;
    localparam logic [CW-1:0] RST_W_M1 = CW'(RST_W - 1);
    localparam logic [RW-1:0] RST_H_M1 = RW'(RST_H - 1);
    localparam logic [CW-1:0] MAX_W_M1 = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] MAX_H_M1 = RW'(MAX_HEIGHT - 1);

    logic [PIXEL_W-1:0] mem [0:DEPTH-1];

    logic [CW-1:0]      r_width_m1;
    logic [RW-1:0]      r_height_m1;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic               r_differs;
    logic               r_first;
    logic [PIXEL_W-1:0] r_pix;
    logic               r_force;
    logic [PIXEL_W-1:0] r_rd_data;
    logic               r_out_valid;
    logic [ROW_NUM_W-1:0] r_out_row;
    logic               r_out_last;

    logic [AW-1:0]      addr;
    logic [PIXEL_W-1:0] prev_pix;
    logic               diff;
    logic               col_last;
    logic               row_last;
    logic               finish;
    logic               emit;
    logic [CW-1:0]      cfg_width_m1;
    logic [RW-1:0]      cfg_height_m1;

    assign addr     = {r_row, r_col};
    assign prev_pix = r_first ? '0 : r_rd_data;
    assign diff     = (prev_pix != r_pix) || r_force || r_differs;
    assign col_last = (r_col == r_width_m1);
    assign row_last = (r_row == r_height_m1);
    assign finish   = (i_cmd.pix_step || i_cmd.clr_step) && col_last;
    assign emit     = (i_cmd.pix_step && col_last && (diff || row_last))
                    || (i_cmd.clr_step && col_last);

    assign o_status.col_last = col_last;
    assign o_status.pix_emit = col_last && (diff || row_last);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // out-of-range sizes clamp to one and to the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_width_m1  = '0;
            cfg_height_m1 = '0;
        end else begin
            cfg_width_m1  = CW'(i_cfg_data - 1'b1);
            cfg_height_m1 = RW'(i_cfg_data - 1'b1);
        end
        if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            cfg_width_m1 = MAX_W_M1;
        end
        if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            cfg_height_m1 = MAX_H_M1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_step) begin
            mem[addr] <= r_pix;
        end else if (i_cmd.clr_step) begin
            mem[addr] <= '0;
        end
        if (i_cmd.load) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix   <= i_pixel_value;
            r_force <= i_force_full;
        end
        if (emit) begin
            r_out_row  <= ROW_NUM_W'(r_row);
            r_out_last <= row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_m1  <= RST_W_M1;
            r_height_m1 <= RST_H_M1;
            r_col       <= '0;
            r_row       <= '0;
            r_differs   <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.cfg_wr) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    r_width_m1 <= cfg_width_m1;
                end
                if (i_cfg_index == REG_FRAME_HEIGHT) begin
                    r_height_m1 <= cfg_height_m1;
                end
                if (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT) begin
                    r_col     <= '0;
                    r_row     <= '0;
                    r_differs <= 1'b0;
                    r_first   <= 1'b1;
                end
            end else if (i_cmd.clr_start) begin
                r_col <= '0;
            end else if (finish) begin
                r_col     <= '0;
                r_differs <= 1'b0;
                if (row_last) begin
                    r_row   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else if (i_cmd.pix_step) begin
                r_col     <= r_col + 1'b1;
                r_differs <= diff;
            end else if (i_cmd.clr_step) begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_number  = r_out_row;
    assign o_row_changed = 1'b1;
    assign o_frame_last  = r_out_last;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_width_m1)
        else $error("column position beyond row width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_height_m1)
        else $error("row position beyond frame height");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending transfer");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cfg_wr && (i_cfg_index == REG_FRAME_WIDTH
                          || i_cfg_index == REG_FRAME_HEIGHT))
        |=> (r_first && r_col == '0 && r_row == '0))
        else $error("register write did not restart the frame");

endmodule

// ===== hdl/frame_changed_row_detector.sv =====
// an accepted pixel is registered with its stored value (memory read); S_CMP then
// compares and writes it back before another pixel is taken. An absent row zeroes
// one store entry per cycle; both stall a row result while the result register is full
// reset: frame_width and frame_height read 512, position and result register clear
// the store reads as zero until one full frame has passed after reset or a size write
module frame_changed_row_detector #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fcrd_pkg::PIXEL_W-1:0]       i_pixel_value,
    input  logic                               i_row_absent,
    input  logic                               i_force_full,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fcrd_pkg::ROW_NUM_W-1:0]     o_row_number,
    output logic                               o_row_changed,
    output logic                               o_frame_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fcrd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcrd_pkg::CFG_W-1:0]         i_cfg_data
);
    import fcrd_pkg::*;

    t_cmd    cmd;
    t_status status;

    fcrd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_row_absent (i_row_absent),
        .o_in_ready   (o_in_ready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    fcrd_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_value (i_pixel_value),
        .i_force_full  (i_force_full),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_number  (o_row_number),
        .o_row_changed (o_row_changed),
        .o_frame_last  (o_frame_last)
    );

endmodule

// ===== tb/frame_changed_row_detector_test.sv =====
module frame_changed_row_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fcrd_pkg::*;

    localparam int MAX_W = 512;
    localparam int MAX_H = 512;
    localparam int SETTLE_CYCLES = MAX_W + 8;
    localparam int STALL_LIMIT = 600000;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] row_number;
        logic                 row_changed;
        logic                 frame_last;
    } t_row_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PIXEL_W-1:0]   i_pixel_value;
    logic                 i_row_absent;
    logic                 i_force_full;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ROW_NUM_W-1:0] o_row_number;
    logic                 o_row_changed;
    logic                 o_frame_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // mirror of the block state
    logic [PIXEL_W-1:0] frame_mem [0:MAX_W*MAX_H-1];
    logic [CFG_W-1:0]   cfg_width;
    logic [CFG_W-1:0]   cfg_height;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic               row_dirty;

    t_row_report pending_reports [$];
    t_row_report report_head;

    int  fail_count;
    int  ready_hold;
    int  stall_cycles;
    int  pixels_sent;
    bit  gaps_on;

    frame_changed_row_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .i_row_absent  (i_row_absent),
        .i_force_full  (i_force_full),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_number  (o_row_number),
        .o_row_changed (o_row_changed),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned fit_size(input int unsigned value, input int unsigned limit);
        if (value < 1) begin
            return 1;
        end
        if (value > limit) begin
            return limit;
        end
        return value;
    endfunction

    function automatic void restart_frame();
        foreach (frame_mem[i]) begin
            frame_mem[i] = '0;
        end
        col_pos   = 0;
        row_pos   = 0;
        row_dirty = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
        if (idx == REG_FRAME_WIDTH) begin
            cfg_width = value;
            restart_frame();
        end else if (idx == REG_FRAME_HEIGHT) begin
            cfg_height = value;
            restart_frame();
        end
    endfunction

    function automatic void close_row(input logic changed, input int unsigned h);
        logic        last;
        t_row_report report;
        last = (row_pos + 1 >= h);
        if (changed || last) begin
            report.row_number  = ROW_NUM_W'(row_pos);
            report.row_changed = 1'b1;
            report.frame_last  = last;
            pending_reports    = {pending_reports, report};
        end
        col_pos   = 0;
        row_dirty = 1'b0;
        row_pos   = last ? 0 : row_pos + 1;
    endfunction

    function automatic void track_pixel(input logic [PIXEL_W-1:0] px, input logic absent,
                                        input logic forced);
        int unsigned w;
        int unsigned h;
        int unsigned base;
        int unsigned c;
        w = fit_size(32'(cfg_width), MAX_W);
        h = fit_size(32'(cfg_height), MAX_H);
        if (row_pos >= h) begin
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
        end
        base = row_pos * MAX_W;
        if (absent) begin
            for (c = 0; c < w; c++) begin
                frame_mem[base + c] = '0;
            end
            close_row(1'b1, h);
            return;
        end
        if (frame_mem[base + col_pos] != px || forced) begin
            row_dirty = 1'b1;
        end
        frame_mem[base + col_pos] = px;
        col_pos++;
        if (col_pos >= w) begin
            close_row(row_dirty, h);
        end
    endfunction

    // pixel held at the position the next transfer will land on
    function automatic logic [PIXEL_W-1:0] held_pixel();
        int unsigned r;
        int unsigned c;
        r = (row_pos >= fit_size(32'(cfg_height), MAX_H)) ? 0 : row_pos;
        c = (col_pos >= fit_size(32'(cfg_width), MAX_W)) ? 0 : col_pos;
        return frame_mem[r * MAX_W + c];
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return held_pixel();
        end
        if (roll < 75) begin
            return held_pixel() ^ (24'd1 << $urandom_range(0, 23));
        end
        return 24'($urandom());
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic absent,
                              input logic forced);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= px;
        i_row_absent  <= absent;
        i_force_full  <= forced;
        do @(posedge i_clk); while (!o_in_ready);
        track_pixel(px, absent, forced);
        pixels_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, value);
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h);
        logic        frame_force;
        int unsigned row;
        int unsigned cut;
        frame_force = ($urandom_range(0, 6) == 0);
        for (row = 0; row < h; row++) begin
            if ($urandom_range(0, 19) < 3) begin
                // partial row, then the whole row goes absent
                cut = $urandom_range(0, w - 1);
                repeat (cut) send_pixel(pick_pixel(), 1'b0, frame_force);
                send_pixel(24'($urandom()), 1'b1, 1'($urandom_range(0, 1)));
            end else begin
                repeat (w) begin
                    send_pixel(pick_pixel(), 1'b0,
                               frame_force ^ ($urandom_range(0, 29) == 0));
                end
            end
        end
    endtask

    // sizes after reset: absent row, partial row
    task automatic test_reset_sizes();
        send_pixel(24'hABCDEF, 1'b1, 1'b1);
        repeat (3) send_pixel(24'($urandom()), 1'b0, 1'b0);
        send_pixel('0, 1'b1, 1'b0);
    endtask

    task automatic test_basic_rows();
        write_reg(REG_FRAME_WIDTH, 10'd4);
        write_reg(REG_FRAME_HEIGHT, 10'd3);
        // extremes in row 0, quiet rows after it
        send_pixel(24'h000000, 1'b0, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0, 1'b0);
        send_pixel(24'h800000, 1'b0, 1'b0);
        send_pixel(24'h000001, 1'b0, 1'b0);
        repeat (8) send_pixel('0, 1'b0, 1'b0);
        // row 0 repeats, row 1 forced on one pixel, row 2 absent
        send_pixel(24'h000000, 1'b0, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0, 1'b0);
        send_pixel(24'h800000, 1'b0, 1'b0);
        send_pixel(24'h000001, 1'b0, 1'b0);
        send_pixel('0, 1'b0, 1'b0);
        send_pixel('0, 1'b0, 1'b1);
        send_pixel('0, 1'b0, 1'b0);
        send_pixel('0, 1'b0, 1'b0);
        send_pixel(24'hFFFFFF, 1'b1, 1'b1);
        // partial row 0 then absent, quiet row 1, quiet last row
        send_pixel(24'h123456, 1'b0, 1'b0);
        send_pixel(24'h00FF00, 1'b0, 1'b0);
        send_pixel(24'h7F7F7F, 1'b1, 1'b0);
        repeat (8) send_pixel('0, 1'b0, 1'b0);
    endtask

    task automatic test_size_limits();
        // zero width acts as one, oversize height runs past many rows
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '1);
        repeat (40) send_pixel(24'($urandom()), 1'b0, 1'b1);
        write_reg(REG_FRAME_HEIGHT, 10'd3);
        repeat (6) send_pixel(24'($urandom()), 1'b0, 1'b0);
        // unmapped indexes leave sizes and store alone
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '0);
        repeat (6) send_pixel(held_pixel(), 1'b0, 1'b0);
        // oversize width, zero height acts as one
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, '0);
        repeat (5) send_pixel(24'($urandom()), 1'b0, 1'b0);
        send_pixel(24'($urandom()), 1'b1, 1'b0);
        repeat (5) send_pixel('0, 1'b0, 1'b0);
        send_pixel('0, 1'b1, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        stop_at = pixels_sent + 220;
        while (pixels_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                w      = $urandom_range(16, 32);
                h      = $urandom_range(1, 2);
                frames = $urandom_range(1, 2);
            end else begin
                w      = $urandom_range(1, 8);
                h      = $urandom_range(1, 6);
                frames = $urandom_range(2, 4);
            end
            write_reg(REG_FRAME_WIDTH, CFG_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
            repeat (frames) send_frame(w, h);
            if ($urandom_range(0, 3) == 0) begin
                // broken frame cut short by the next size write
                repeat ($urandom_range(1, w * h)) begin
                    send_pixel(24'($urandom()), $urandom_range(0, 9) == 0,
                               1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        write_reg(REG_FRAME_WIDTH, 10'd5);
        write_reg(REG_FRAME_HEIGHT, 10'd3);
        repeat (4) send_frame(5, 3);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("row report with none expected: row_number %0d", o_row_number);
                fail_count++;
            end else begin
                report_head = pending_reports.pop_front();
                if (o_row_number !== report_head.row_number) begin
                    $error("row_number: expected %0d, got %0d",
                           report_head.row_number, o_row_number);
                    fail_count++;
                end
                if (o_row_changed !== report_head.row_changed) begin
                    $error("row_changed: expected %0b, got %0b",
                           report_head.row_changed, o_row_changed);
                    fail_count++;
                end
                if (o_frame_last !== report_head.frame_last) begin
                    $error("frame_last: expected %0b, got %0b",
                           report_head.frame_last, o_frame_last);
                    fail_count++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            ready_hold  <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("frame_changed_row_detector_test NOT OK");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_pixel_value <= '0;
        i_row_absent  <= 1'b0;
        i_force_full  <= 1'b0;
        i_out_ready   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_FRAME_WIDTH;
        i_cfg_data    <= '0;
        fail_count  = 0;
        ready_hold  = 0;
        pixels_sent = 0;
        gaps_on     = 1'b1;
        cfg_width   = 10'd512;
        cfg_height  = 10'd512;
        restart_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_sizes();
        test_basic_rows();
        test_size_limits();
        test_random_frames();
        test_steady_stream();
        settle();
        if (fail_count == 0) begin
            $display("frame_changed_row_detector_test OK");
        end else begin
            $display("frame_changed_row_detector_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fcrd_pkg.sv
hdl/fcrd_ctrl.sv
hdl/fcrd_dpath.sv
hdl/frame_changed_row_detector.sv
tb/frame_changed_row_detector_test.sv
